// ===== rtl/core/kfd_pkg.sv =====
// ----------------------------------------------------------------------------
// KISS frame deframer package
// Shared types, framing symbols and event codes of the KISS deframer.
// ----------------------------------------------------------------------------
package kfd_pkg;

  localparam logic [7:0] SYM_FEND  = 8'hC0;
  localparam logic [7:0] SYM_FESC  = 8'hDB;
  localparam logic [7:0] SYM_TFEND = 8'hDC;
  localparam logic [7:0] SYM_TFESC = 8'hDD;

  localparam logic [7:0] CMD_DATA    = 8'h00;
  localparam logic [7:0] CMD_PERSIST = 8'h02;
  localparam logic [7:0] CMD_SLOT    = 8'h03;
  localparam logic [7:0] CMD_SETHW   = 8'h06;

  localparam logic [1:0] EV_BYTE  = 2'd0;
  localparam logic [1:0] EV_END   = 2'd1;
  localparam logic [1:0] EV_ABORT = 2'd2;
  localparam logic [1:0] EV_PARAM = 2'd3;

  localparam logic [7:0]  PERSIST_RESET = 8'd255;
  localparam logic [11:0] SLOT_RESET    = 12'd0;

  typedef enum logic [2:0] {
    ST_HUNT    = 3'd0,
    ST_CMD     = 3'd1,
    ST_PERSIST = 3'd2,
    ST_SLOT    = 3'd3,
    ST_DATA    = 3'd4,
    ST_ESC     = 3'd5,
    ST_SKIP    = 3'd6
  } kfd_state_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic        frame_kind;
    logic [7:0]  payload;
    logic [8:0]  length;
    logic [7:0]  persistence;
    logic [11:0] slot_time;
  } kfd_result_t;

endpackage

// ===== rtl/core/kfd_in_stage.sv =====
// ----------------------------------------------------------------------------
// KISS deframer input stage
// Registers one serial byte and holds it while the result side is stalled.
// ----------------------------------------------------------------------------
module kfd_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       serial_valid,
  output logic       serial_stall,
  input  logic [7:0] serial_byte,
  input  logic       advance,
  output logic       item_valid,
  output logic [7:0] item_byte
);

  logic       valid_q;
  logic [7:0] byte_q;

  assign serial_stall = valid_q && !advance;
  assign item_valid   = valid_q;
  assign item_byte    = byte_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (!serial_stall) begin
      valid_q <= serial_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!serial_stall && serial_valid) begin
      byte_q <= serial_byte;
    end
  end

endmodule

// ===== rtl/core/kfd_parser.sv =====
// ----------------------------------------------------------------------------
// KISS deframer parser
// Framing state machine with byte count and CSMA parameter registers.
// ----------------------------------------------------------------------------
module kfd_parser #(
  parameter int MAX_FRAME = 255
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  logic [7:0]           item_byte,
  input  logic                 advance,
  output kfd_pkg::kfd_result_t result,
  output logic [8:0]           byte_count
);

  kfd_pkg::kfd_state_t state, state_next;
  logic        frame_type, frame_type_next;
  logic [8:0]  count, count_next;
  logic [7:0]  persist, persist_next;
  logic [11:0] slot, slot_next;

  logic        aborted;
  logic        emit;
  logic [1:0]  kind;
  logic [7:0]  pbyte;
  logic [8:0]  plen;
  kfd_pkg::kfd_state_t cur;

  assign byte_count = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= kfd_pkg::ST_HUNT;
      frame_type <= 1'b0;
      count      <= 9'd0;
      persist    <= kfd_pkg::PERSIST_RESET;
      slot       <= kfd_pkg::SLOT_RESET;
    end else if (item_valid && advance) begin
      state      <= state_next;
      frame_type <= frame_type_next;
      count      <= count_next;
      persist    <= persist_next;
      slot       <= slot_next;
    end
  end

  always_comb begin
    cur             = state;
    count_next      = count;
    frame_type_next = frame_type;
    persist_next    = persist;
    slot_next       = slot;
    aborted         = 1'b0;
    emit            = 1'b0;
    kind            = kfd_pkg::EV_BYTE;
    pbyte           = 8'd0;
    plen            = 9'd0;

    if (count > 9'(MAX_FRAME)) begin
      cur        = kfd_pkg::ST_HUNT;
      count_next = 9'd0;
      aborted    = 1'b1;
    end
    state_next = cur;

    case (cur)
      kfd_pkg::ST_HUNT: begin
        if (item_byte == kfd_pkg::SYM_FEND) begin
          state_next = kfd_pkg::ST_CMD;
        end
      end
      kfd_pkg::ST_SKIP: begin
        if (item_byte == kfd_pkg::SYM_FEND) begin
          state_next = kfd_pkg::ST_HUNT;
        end
      end
      kfd_pkg::ST_CMD: begin
        if (item_byte == kfd_pkg::CMD_DATA) begin
          count_next      = 9'd0;
          frame_type_next = 1'b0;
          state_next      = kfd_pkg::ST_DATA;
        end else if (item_byte == kfd_pkg::CMD_PERSIST) begin
          state_next = kfd_pkg::ST_PERSIST;
        end else if (item_byte == kfd_pkg::CMD_SLOT) begin
          state_next = kfd_pkg::ST_SLOT;
        end else if (item_byte == kfd_pkg::CMD_SETHW) begin
          count_next      = 9'd0;
          frame_type_next = 1'b1;
          state_next      = kfd_pkg::ST_DATA;
        end else if (item_byte != kfd_pkg::SYM_FEND) begin
          state_next = kfd_pkg::ST_SKIP;
        end
      end
      kfd_pkg::ST_PERSIST: begin
        persist_next = item_byte;
        state_next   = kfd_pkg::ST_SKIP;
        emit         = 1'b1;
        kind         = kfd_pkg::EV_PARAM;
      end
      kfd_pkg::ST_SLOT: begin
        slot_next  = {1'b0, item_byte, 3'b000} + {3'b000, item_byte, 1'b0};
        state_next = kfd_pkg::ST_SKIP;
        emit       = 1'b1;
        kind       = kfd_pkg::EV_PARAM;
      end
      kfd_pkg::ST_DATA: begin
        if (item_byte == kfd_pkg::SYM_FESC) begin
          state_next = kfd_pkg::ST_ESC;
        end else if (item_byte == kfd_pkg::SYM_FEND) begin
          plen       = count_next;
          count_next = 9'd0;
          state_next = kfd_pkg::ST_HUNT;
          emit       = 1'b1;
          kind       = kfd_pkg::EV_END;
        end else begin
          count_next = count_next + 9'd1;
          emit       = 1'b1;
          kind       = kfd_pkg::EV_BYTE;
          pbyte      = item_byte;
        end
      end
      kfd_pkg::ST_ESC: begin
        if (item_byte == kfd_pkg::SYM_TFEND) begin
          count_next = count_next + 9'd1;
          state_next = kfd_pkg::ST_DATA;
          emit       = 1'b1;
          kind       = kfd_pkg::EV_BYTE;
          pbyte      = kfd_pkg::SYM_FEND;
        end else if (item_byte == kfd_pkg::SYM_TFESC) begin
          count_next = count_next + 9'd1;
          state_next = kfd_pkg::ST_DATA;
          emit       = 1'b1;
          kind       = kfd_pkg::EV_BYTE;
          pbyte      = kfd_pkg::SYM_FESC;
        end else if (item_byte != kfd_pkg::SYM_FEND) begin
          state_next = kfd_pkg::ST_SKIP;
        end
      end
      default: begin
        state_next = kfd_pkg::ST_HUNT;
      end
    endcase

    if (!emit && aborted) begin
      emit = 1'b1;
      kind = kfd_pkg::EV_ABORT;
    end

    result.valid       = item_valid && emit;
    result.kind        = kind;
    result.frame_kind  = frame_type_next;
    result.payload     = pbyte;
    result.length      = plen;
    result.persistence = persist_next;
    result.slot_time   = slot_next;
  end

endmodule

// ===== rtl/core/kfd_out_reg.sv =====
// ----------------------------------------------------------------------------
// KISS deframer result register
// Holds one decoded event until the receiving side takes it.
// ----------------------------------------------------------------------------
module kfd_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  kfd_pkg::kfd_result_t result,
  output logic                 advance,
  output logic                 event_valid,
  input  logic                 event_stall,
  output logic [1:0]           event_kind,
  output logic                 frame_kind,
  output logic [7:0]           payload_byte,
  output logic [8:0]           frame_length,
  output logic [7:0]           persistence,
  output logic [11:0]          slot_time_ms
);

  logic                 valid_q;
  kfd_pkg::kfd_result_t data_q;

  assign advance      = !valid_q || !event_stall;
  assign event_valid  = valid_q;
  assign event_kind   = data_q.kind;
  assign frame_kind   = data_q.frame_kind;
  assign payload_byte = data_q.payload;
  assign frame_length = data_q.length;
  assign persistence  = data_q.persistence;
  assign slot_time_ms = data_q.slot_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (advance) begin
      valid_q <= result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      data_q <= result;
    end
  end

endmodule

// ===== rtl/core/kiss_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// KISS frame deframer
// An accepted byte is held in the input register and its event in the result register.
// Throughput: one serial byte per cycle while the result side does not stall,
// set by the combinational parser step between the input and result registers.
// Reset: the parser hunts for an opening FEND, persistence is 255 and the
// slot time is zero.
// ----------------------------------------------------------------------------
module kiss_frame_deframer #(
  parameter int MAX_FRAME = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        serial_valid,
  output logic        serial_stall,
  input  logic [7:0]  serial_byte,
  output logic        event_valid,
  input  logic        event_stall,
  output logic [1:0]  event_kind,
  output logic        frame_kind,
  output logic [7:0]  payload_byte,
  output logic [8:0]  frame_length,
  output logic [7:0]  persistence,
  output logic [11:0] slot_time_ms
);

  logic                 advance;
  logic                 item_valid;
  logic [8:0]           byte_count;
  kfd_pkg::kfd_result_t result;
  logic [7:0]           item_byte;

  kfd_in_stage u_in (
    .clk          (clk),
    .rst          (rst),
    .serial_valid (serial_valid),
    .serial_stall (serial_stall),
    .serial_byte  (serial_byte),
    .advance      (advance),
    .item_valid   (item_valid),
    .item_byte    (item_byte)
  );

  kfd_parser #(
    .MAX_FRAME (MAX_FRAME)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_byte  (item_byte),
    .advance    (advance),
    .result     (result),
    .byte_count (byte_count)
  );

  kfd_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .result       (result),
    .advance      (advance),
    .event_valid  (event_valid),
    .event_stall  (event_stall),
    .event_kind   (event_kind),
    .frame_kind   (frame_kind),
    .payload_byte (payload_byte),
    .frame_length (frame_length),
    .persistence  (persistence),
    .slot_time_ms (slot_time_ms)
  );

  // The byte count never runs more than one past the frame limit.
  assert property (@(posedge clk) disable iff (rst)
    byte_count <= 9'(MAX_FRAME + 1))
    else $error("byte count beyond frame limit");

  // A frame end never reports more bytes than the frame limit.
  assert property (@(posedge clk) disable iff (rst)
    event_valid && event_kind == kfd_pkg::EV_END |-> frame_length <= 9'(MAX_FRAME))
    else $error("frame length beyond frame limit");

  // The input side stalls only while a byte is held in the input register.
  assert property (@(posedge clk) disable iff (rst)
    serial_stall |-> item_valid && event_valid && event_stall)
    else $error("input stalled without a held byte");

  // Only payload byte events carry a nonzero payload byte.
  assert property (@(posedge clk) disable iff (rst)
    event_valid && event_kind != kfd_pkg::EV_BYTE |-> payload_byte == 8'd0)
    else $error("payload byte set on a non-payload event");

endmodule

// ===== verif/kfd_event_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// KISS deframer event checker
// Runs every accepted serial byte through its own KISS parser, queues the
// events that byte should cause and compares each accepted event, field by
// field, with the oldest one waiting. It reports a mismatch count and the
// number of events still outstanding.
// ----------------------------------------------------------------------------
module kfd_event_checker #(
  parameter int MAX_FRAME = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        serial_valid,
  input  logic        serial_stall,
  input  logic [7:0]  serial_byte,
  input  logic        event_valid,
  input  logic        event_stall,
  input  logic [1:0]  event_kind,
  input  logic        frame_kind,
  input  logic [7:0]  payload_byte,
  input  logic [8:0]  frame_length,
  input  logic [7:0]  persistence,
  input  logic [11:0] slot_time_ms,
  output int          mismatches,
  output int          waiting
);

  typedef struct packed {
    logic [1:0]  kind;
    logic        frame_kind;
    logic [7:0]  payload;
    logic [8:0]  length;
    logic [7:0]  persistence;
    logic [11:0] slot_time;
  } kiss_event_t;

  kfd_pkg::kfd_state_t parse_st;
  logic        frame_hw;
  logic [8:0]  payload_count;
  logic [7:0]  persist_p;
  logic [11:0] slot_ms;
  kiss_event_t predicted_events[$];

  function automatic void queue_event(input logic [1:0] kind, input logic [7:0] payload,
                                      input logic [8:0] length);
    kiss_event_t ev;
    ev.kind        = kind;
    ev.frame_kind  = frame_hw;
    ev.payload     = payload;
    ev.length      = length;
    ev.persistence = persist_p;
    ev.slot_time   = slot_ms;
    predicted_events.push_back(ev);
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    logic overflowed;
    overflowed = 1'b0;
    // A frame that has grown past the limit is dropped on the next byte,
    // which the hunt state then handles.
    if (payload_count > 9'(MAX_FRAME)) begin
      parse_st      = kfd_pkg::ST_HUNT;
      payload_count = '0;
      overflowed    = 1'b1;
    end
    case (parse_st)
      kfd_pkg::ST_HUNT: begin
        if (b == kfd_pkg::SYM_FEND) parse_st = kfd_pkg::ST_CMD;
      end
      kfd_pkg::ST_SKIP: begin
        if (b == kfd_pkg::SYM_FEND) parse_st = kfd_pkg::ST_HUNT;
      end
      kfd_pkg::ST_CMD: begin
        if (b == kfd_pkg::CMD_DATA) begin
          payload_count = '0;
          frame_hw      = 1'b0;
          parse_st      = kfd_pkg::ST_DATA;
        end else if (b == kfd_pkg::CMD_PERSIST) begin
          parse_st = kfd_pkg::ST_PERSIST;
        end else if (b == kfd_pkg::CMD_SLOT) begin
          parse_st = kfd_pkg::ST_SLOT;
        end else if (b == kfd_pkg::CMD_SETHW) begin
          payload_count = '0;
          frame_hw      = 1'b1;
          parse_st      = kfd_pkg::ST_DATA;
        end else if (b != kfd_pkg::SYM_FEND) begin
          parse_st = kfd_pkg::ST_SKIP;
        end
      end
      kfd_pkg::ST_PERSIST: begin
        persist_p = b;
        parse_st  = kfd_pkg::ST_SKIP;
        queue_event(kfd_pkg::EV_PARAM, 8'd0, 9'd0);
        return;
      end
      kfd_pkg::ST_SLOT: begin
        slot_ms  = 12'(b) * 12'd10;
        parse_st = kfd_pkg::ST_SKIP;
        queue_event(kfd_pkg::EV_PARAM, 8'd0, 9'd0);
        return;
      end
      kfd_pkg::ST_DATA: begin
        if (b == kfd_pkg::SYM_FESC) begin
          parse_st = kfd_pkg::ST_ESC;
        end else if (b == kfd_pkg::SYM_FEND) begin
          queue_event(kfd_pkg::EV_END, 8'd0, payload_count);
          payload_count = '0;
          parse_st      = kfd_pkg::ST_HUNT;
          return;
        end else begin
          payload_count = payload_count + 9'd1;
          queue_event(kfd_pkg::EV_BYTE, b, 9'd0);
          return;
        end
      end
      kfd_pkg::ST_ESC: begin
        if (b == kfd_pkg::SYM_TFEND) begin
          payload_count = payload_count + 9'd1;
          parse_st      = kfd_pkg::ST_DATA;
          queue_event(kfd_pkg::EV_BYTE, kfd_pkg::SYM_FEND, 9'd0);
          return;
        end else if (b == kfd_pkg::SYM_TFESC) begin
          payload_count = payload_count + 9'd1;
          parse_st      = kfd_pkg::ST_DATA;
          queue_event(kfd_pkg::EV_BYTE, kfd_pkg::SYM_FESC, 9'd0);
          return;
        end else if (b != kfd_pkg::SYM_FEND) begin
          parse_st = kfd_pkg::ST_SKIP;
        end
      end
      default: begin
        parse_st = kfd_pkg::ST_HUNT;
      end
    endcase
    if (overflowed) queue_event(kfd_pkg::EV_ABORT, 8'd0, 9'd0);
  endfunction

  function automatic void compare_field(input string name, input logic [11:0] expected_v,
                                        input logic [11:0] actual_v);
    if (expected_v !== actual_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name,
               expected_v, actual_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    kiss_event_t exp_ev;
    if (rst) begin
      parse_st      = kfd_pkg::ST_HUNT;
      frame_hw      = 1'b0;
      payload_count = '0;
      persist_p     = kfd_pkg::PERSIST_RESET;
      slot_ms       = kfd_pkg::SLOT_RESET;
      predicted_events.delete();
    end else begin
      if (serial_valid && !serial_stall) deframe_byte(serial_byte);
      if (event_valid && !event_stall) begin
        if (predicted_events.size() == 0) begin
          $display("%0t: unexpected event, expected none, actual kind %0d", $time, event_kind);
          mismatches++;
        end else begin
          exp_ev = predicted_events.pop_front();
          compare_field("event_kind", 12'(exp_ev.kind), 12'(event_kind));
          compare_field("frame_kind", 12'(exp_ev.frame_kind), 12'(frame_kind));
          compare_field("payload_byte", 12'(exp_ev.payload), 12'(payload_byte));
          compare_field("frame_length", 12'(exp_ev.length), 12'(frame_length));
          compare_field("persistence", 12'(exp_ev.persistence), 12'(persistence));
          compare_field("slot_time_ms", exp_ev.slot_time, slot_time_ms);
        end
      end
    end
    waiting <= predicted_events.size();
  end

endmodule

// ===== verif/kiss_frame_deframer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// KISS frame deframer testbench
// Feeds the deframer a directed set of frames, a frame past the length
// limit, and then a random mix of data, set-hardware, parameter, broken
// and unknown-command frames with noise between them. Both channels
// idle at random. A separate checker predicts and compares every event.
// ----------------------------------------------------------------------------
module kiss_frame_deframer_tb;

  localparam int MAX_FRAME    = 255;
  localparam int RANDOM_ITEMS = 150;
  localparam int IDLE_LIMIT   = 1000;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        serial_valid = 1'b0;
  logic        serial_stall;
  logic [7:0]  serial_byte  = 8'd0;
  logic        event_valid;
  logic        event_stall  = 1'b0;
  logic [1:0]  event_kind;
  logic        frame_kind;
  logic [7:0]  payload_byte;
  logic [8:0]  frame_length;
  logic [7:0]  persistence;
  logic [11:0] slot_time_ms;
  int          mismatches;
  int          waiting;

  bit idle_on       = 1'b1;
  int stream_items  = 0;
  int noise_items   = 0;
  int idle_cycles   = 0;

  always #5 clk = ~clk;

  kiss_frame_deframer #(
    .MAX_FRAME(MAX_FRAME)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .serial_valid(serial_valid),
    .serial_stall(serial_stall),
    .serial_byte (serial_byte),
    .event_valid (event_valid),
    .event_stall (event_stall),
    .event_kind  (event_kind),
    .frame_kind  (frame_kind),
    .payload_byte(payload_byte),
    .frame_length(frame_length),
    .persistence (persistence),
    .slot_time_ms(slot_time_ms)
  );

  kfd_event_checker #(
    .MAX_FRAME(MAX_FRAME)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .serial_valid(serial_valid),
    .serial_stall(serial_stall),
    .serial_byte (serial_byte),
    .event_valid (event_valid),
    .event_stall (event_stall),
    .event_kind  (event_kind),
    .frame_kind  (frame_kind),
    .payload_byte(payload_byte),
    .frame_length(frame_length),
    .persistence (persistence),
    .slot_time_ms(slot_time_ms),
    .mismatches  (mismatches),
    .waiting     (waiting)
  );

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      serial_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    serial_valid <= 1'b1;
    serial_byte  <= b;
    @(posedge clk);
    while (serial_stall) @(posedge clk);
    stream_items++;
  endtask

  task automatic send_payload(input logic [7:0] b);
    if (b == kfd_pkg::SYM_FEND) begin
      send_byte(kfd_pkg::SYM_FESC);
      send_byte(kfd_pkg::SYM_TFEND);
    end else if (b == kfd_pkg::SYM_FESC) begin
      send_byte(kfd_pkg::SYM_FESC);
      send_byte(kfd_pkg::SYM_TFESC);
    end else begin
      send_byte(b);
    end
  endtask

  // Opening FEND, command byte and the escaped payload; no closing byte.
  task automatic send_frame(input logic [7:0] cmd, input int n_bytes);
    send_byte(kfd_pkg::SYM_FEND);
    send_byte(cmd);
    repeat (n_bytes) send_payload(8'($urandom));
  endtask

  task automatic drain_events();
    serial_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  initial begin
    int n;
    forever begin
      n = idle_on ? $urandom_range(0, 7) : 0;
      if (n > 0) begin
        event_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      event_stall <= 1'b0;
      @(posedge clk);
      while (!event_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (serial_valid && !serial_stall) || (event_valid && !event_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int         pick;
    int         n;
    logic [7:0] b;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Persistence set to its minimum; the byte after the value is skipped.
    send_byte(kfd_pkg::SYM_FEND); send_byte(kfd_pkg::CMD_PERSIST); send_byte(8'h00);
    send_byte(8'h33); send_byte(kfd_pkg::SYM_FEND);
    // Slot time at its maximum.
    send_byte(kfd_pkg::SYM_FEND); send_byte(kfd_pkg::CMD_SLOT); send_byte(8'hFF);
    send_byte(kfd_pkg::SYM_FEND);
    // Repeated FEND, both escapes, and an FEND inside an escape that is ignored.
    send_byte(kfd_pkg::SYM_FEND); send_byte(kfd_pkg::SYM_FEND); send_byte(kfd_pkg::CMD_DATA);
    send_byte(8'h41);
    send_byte(kfd_pkg::SYM_FESC); send_byte(kfd_pkg::SYM_TFEND); send_byte(kfd_pkg::SYM_FESC);
    send_byte(kfd_pkg::SYM_FEND);
    send_byte(kfd_pkg::SYM_TFESC); send_byte(kfd_pkg::SYM_FEND);
    // A byte after the closing FEND is ignored while hunting.
    send_byte(8'h55);
    // Set-hardware frame abandoned by a bad escape.
    send_byte(kfd_pkg::SYM_FEND); send_byte(kfd_pkg::CMD_SETHW); send_byte(kfd_pkg::SYM_FESC);
    send_byte(8'h12);
    send_byte(kfd_pkg::SYM_FEND);
    // Unknown command.
    send_byte(kfd_pkg::SYM_FEND); send_byte(8'h07); send_byte(kfd_pkg::SYM_FEND);
    drain_events();

    // A frame one byte past the length limit; its closing FEND opens the next frame.
    idle_on = 1'b0;
    send_frame(kfd_pkg::CMD_SETHW, MAX_FRAME + 1);
    send_byte(kfd_pkg::SYM_FEND);
    send_frame(kfd_pkg::CMD_DATA, 2);
    send_byte(kfd_pkg::SYM_FEND);
    drain_events();

    stream_items = 0;
    noise_items  = 0;
    while (stream_items - noise_items < RANDOM_ITEMS) begin
      pick    = $urandom_range(0, 99);
      idle_on = ($urandom_range(0, 3) != 0);
      if (pick < 60) begin
        if ($urandom_range(0, 3) == 0) send_byte(kfd_pkg::SYM_FEND);
        send_frame(($urandom_range(0, 2) == 0) ? kfd_pkg::CMD_SETHW : kfd_pkg::CMD_DATA,
                   $urandom_range(0, 20));
        send_byte(kfd_pkg::SYM_FEND);
      end else if (pick < 70) begin
        send_byte(kfd_pkg::SYM_FEND);
        send_byte($urandom_range(0, 1) ? kfd_pkg::CMD_PERSIST : kfd_pkg::CMD_SLOT);
        send_byte(8'($urandom));
        if ($urandom_range(0, 1)) send_byte(8'($urandom));
        send_byte(kfd_pkg::SYM_FEND);
      end else if (pick < 80) begin
        send_frame(kfd_pkg::CMD_DATA, $urandom_range(0, 6));
        send_byte(kfd_pkg::SYM_FESC);
        if ($urandom_range(0, 1)) begin
          send_byte(kfd_pkg::SYM_FEND);
          send_byte($urandom_range(0, 1) ? kfd_pkg::SYM_TFEND : kfd_pkg::SYM_TFESC);
        end else begin
          do b = 8'($urandom);
          while (b == kfd_pkg::SYM_FEND || b == kfd_pkg::SYM_TFEND || b == kfd_pkg::SYM_TFESC);
          send_byte(b);
          repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
        end
        send_byte(kfd_pkg::SYM_FEND);
      end else if (pick < 90) begin
        do b = 8'($urandom);
        while (b == kfd_pkg::CMD_DATA || b == kfd_pkg::CMD_PERSIST || b == kfd_pkg::CMD_SLOT ||
               b == kfd_pkg::CMD_SETHW || b == kfd_pkg::SYM_FEND);
        send_byte(kfd_pkg::SYM_FEND);
        send_byte(b);
        repeat ($urandom_range(0, 4)) send_byte(8'($urandom));
        send_byte(kfd_pkg::SYM_FEND);
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) send_byte(8'($urandom));
        noise_items += n;
      end
      if ($urandom_range(0, 29) == 0) drain_events();
    end

    drain_events();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && waiting == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
